[rtl/core/twr_pkg.sv]
// ----------------------------------------------------------------------------
// twr_pkg
// Shared types and constants of the two-way ranging initiator sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package twr_pkg;

   // Width of every radio timestamp and interval
   localparam int TIME_BITS = 40;

   // Reset value of the poll delay register
   localparam logic [TIME_BITS-1:0] POLL_DELAY_RESET = TIME_BITS'(64'h0000_000B_E6E0_0000);

   // Clear the low nine bits of the final send time for the reply intervals
   localparam logic [TIME_BITS-1:0] REPLY_MASK = {{(TIME_BITS-9){1'b1}}, 9'h000};

   // Configuration register indexes
   localparam logic [1:0] CSR_POLL_DELAY  = 2'd0;
   localparam logic [1:0] CSR_RX_A_OFFSET = 2'd1;
   localparam logic [1:0] CSR_RX_B_OFFSET = 2'd2;
   localparam logic [1:0] CSR_FINAL_DELAY = 2'd3;

   // Event kinds carried by an input word
   typedef enum logic [2:0] {
      FUNC_TICK     = 3'd0,
      FUNC_TX_DONE  = 3'd1,
      FUNC_RX_DONE  = 3'd2,
      FUNC_RX_FAIL  = 3'd3,
      FUNC_GEN_FAIL = 3'd4
   } func_type;

   // Ranging stages
   typedef enum logic [1:0] {
      STAGE_POLL   = 2'd0,
      STAGE_RESP_A = 2'd1,
      STAGE_RESP_B = 2'd2,
      STAGE_FINAL  = 2'd3
   } stage_type;

   // Actions issued on a service tick
   typedef enum logic [1:0] {
      ACT_SEND_POLL  = 2'd0,
      ACT_ARM_RX     = 2'd1,
      ACT_SEND_FINAL = 2'd2
   } action_type;

   // Stored stamps of the current exchange
   typedef struct packed {
      logic [TIME_BITS-1:0] poll_tx;
      logic [TIME_BITS-1:0] resp_a;
      logic [TIME_BITS-1:0] resp_b;
   } stamps_type;

   // Delay registers
   typedef struct packed {
      logic [TIME_BITS-1:0] poll_delay;
      logic [TIME_BITS-1:0] rx_a_offset;
      logic [TIME_BITS-1:0] rx_b_offset;
      logic [TIME_BITS-1:0] final_delay;
   } delays_type;

   // One result word
   typedef struct packed {
      action_type           action;
      logic [TIME_BITS-1:0] action_time;
      logic [TIME_BITS-1:0] round_a;
      logic [TIME_BITS-1:0] reply_a;
      logic [TIME_BITS-1:0] round_b;
      logic [TIME_BITS-1:0] reply_b;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/twr_action.sv]
// ----------------------------------------------------------------------------
// twr_action
// Stage action of a service tick: send time or deadline and final intervals.
// ----------------------------------------------------------------------------
`default_nettype none

module twr_action
   import twr_pkg::*;
(
   input  stage_type            stage,
   input  logic [TIME_BITS-1:0] now_time,
   input  stamps_type           stamps,
   input  delays_type           delays,
   output result_type           result
);

   logic [TIME_BITS-1:0] final_send;
   logic [TIME_BITS-1:0] final_masked;

   // Final send time and its masked form for the reply intervals
   assign final_send   = stamps.resp_b + delays.final_delay;
   assign final_masked = final_send & REPLY_MASK;

   // Select the action of the current stage
   always_comb begin
      result = '0;
      unique case (stage)
         STAGE_POLL: begin
            result.action      = ACT_SEND_POLL;
            result.action_time = now_time + delays.poll_delay;
         end
         STAGE_RESP_A: begin
            result.action      = ACT_ARM_RX;
            result.action_time = stamps.poll_tx + delays.rx_a_offset;
         end
         STAGE_RESP_B: begin
            result.action      = ACT_ARM_RX;
            result.action_time = stamps.poll_tx + delays.rx_b_offset;
         end
         STAGE_FINAL: begin
            result.action      = ACT_SEND_FINAL;
            result.action_time = final_send;
            result.round_a     = stamps.resp_a - stamps.poll_tx;
            result.reply_a     = final_masked - stamps.resp_a;
            result.round_b     = stamps.resp_b - stamps.poll_tx;
            result.reply_b     = final_masked - stamps.resp_b;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/two_way_ranging_tag_sequencer_core.sv]
// A result word is loaded into the result register from the input register.
// Throughput: one input word per cycle while the result register is free or
// drained, set by the single processing stage between the input register and
// the result register. Events causing no result also pass that stage.
// Reset clears the stage, the started flag, both valid flags and the delay
// registers to their reset values; the stored stamps are not reset.
// ----------------------------------------------------------------------------
// two_way_ranging_tag_sequencer_core
// Initiator sequencer for double-sided two-way ranging with two responders.
// ----------------------------------------------------------------------------
`default_nettype none

module two_way_ranging_tag_sequencer_core
   import twr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_func,
   input  logic [TIME_BITS-1:0] req_event_time,
   input  logic                 req_msg_is_response,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_action,
   output logic [TIME_BITS-1:0] rsp_action_time,
   output logic [TIME_BITS-1:0] rsp_round_a,
   output logic [TIME_BITS-1:0] rsp_reply_a,
   output logic [TIME_BITS-1:0] rsp_round_b,
   output logic [TIME_BITS-1:0] rsp_reply_b,
   // configuration port
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [TIME_BITS-1:0] csr_wdata
);

   delays_type           delays_ff;
   logic                 in_vld_ff;
   logic [2:0]           in_func_ff;
   logic [TIME_BITS-1:0] in_time_ff;
   logic                 in_resp_ff;
   stage_type            stage_ff;
   stage_type            stage_in;
   logic                 started_ff;
   logic                 started_in;
   stamps_type           stamps_ff;
   stamps_type           stamps_in;
   logic                 out_vld_ff;
   result_type           out_ff;
   result_type           calc;
   logic                 proc_go;
   logic                 emit;

   // Processing stage moves when the result register is free or being drained
   assign proc_go   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || proc_go;

   // Delay registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delays_ff.poll_delay  <= POLL_DELAY_RESET;
         delays_ff.rx_a_offset <= '0;
         delays_ff.rx_b_offset <= '0;
         delays_ff.final_delay <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POLL_DELAY:  delays_ff.poll_delay  <= csr_wdata;
            CSR_RX_A_OFFSET: delays_ff.rx_a_offset <= csr_wdata;
            CSR_RX_B_OFFSET: delays_ff.rx_b_offset <= csr_wdata;
            CSR_FINAL_DELAY: delays_ff.final_delay <= csr_wdata;
         endcase
      end
   end

   // Input register: take a word whenever the stage ahead is free
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_func_ff <= req_func;
         in_time_ff <= req_event_time;
         in_resp_ff <= req_msg_is_response;
      end
   end

   // Stage action for a tick
   twr_action u_action (
      .stage    (stage_ff),
      .now_time (in_time_ff),
      .stamps   (stamps_ff),
      .delays   (delays_ff),
      .result   (calc)
   );

   // Next stage, started flag and stamps for the word in the input register
   always_comb begin
      stage_in   = stage_ff;
      started_in = started_ff;
      stamps_in  = stamps_ff;
      emit       = 1'b0;
      if (proc_go) begin
         unique case (in_func_ff)
            FUNC_TICK: begin
               if (!started_ff) begin
                  started_in = 1'b1;
                  emit       = 1'b1;
               end
            end
            FUNC_TX_DONE: begin
               if (stage_ff == STAGE_POLL) begin
                  stamps_in.poll_tx = in_time_ff;
                  stage_in          = STAGE_RESP_A;
                  started_in        = 1'b0;
               end else if (stage_ff == STAGE_FINAL) begin
                  stage_in   = STAGE_POLL;
                  started_in = 1'b0;
               end
            end
            FUNC_RX_DONE: begin
               if (in_resp_ff) begin
                  if (stage_ff == STAGE_RESP_A) begin
                     stamps_in.resp_a = in_time_ff;
                     stage_in         = STAGE_RESP_B;
                  end else begin
                     stamps_in.resp_b = in_time_ff;
                     stage_in         = STAGE_FINAL;
                  end
               end
               started_in = 1'b0;
            end
            FUNC_RX_FAIL, FUNC_GEN_FAIL: begin
               stage_in   = STAGE_POLL;
               started_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff   <= STAGE_POLL;
         started_ff <= 1'b0;
      end else begin
         stage_ff   <= stage_in;
         started_ff <= started_in;
      end
   end

   // Stamps hold until an event stores a new one
   always_ff @(posedge clock) begin
      stamps_ff <= stamps_in;
   end

   // Result register: load on a new result, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= calc;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_action      = out_ff.action;
   assign rsp_action_time = out_ff.action_time;
   assign rsp_round_a     = out_ff.round_a;
   assign rsp_reply_a     = out_ff.reply_a;
   assign rsp_round_b     = out_ff.round_b;
   assign rsp_reply_b     = out_ff.reply_b;

endmodule

`default_nettype wire

[rtl/core/twr_checker.sv]
// ----------------------------------------------------------------------------
// twr_checker
// Port-level checks of the ranging sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module twr_checker
   import twr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [1:0]           rsp_action,
   input  logic [TIME_BITS-1:0] rsp_action_time,
   input  logic [TIME_BITS-1:0] rsp_round_a,
   input  logic [TIME_BITS-1:0] rsp_reply_a,
   input  logic [TIME_BITS-1:0] rsp_round_b,
   input  logic [TIME_BITS-1:0] rsp_reply_b
);

   // No result word straight after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result word keeps its action, action time and round_b interval
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_action_time) && $stable(rsp_round_b))
      else $error("stalled result word changed");

   // Only the three action codes appear
   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_action <= ACT_SEND_FINAL)
      else $error("undefined action code");

   // Intervals are zero unless the final is sent
   a_zero_intervals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_SEND_FINAL |->
         rsp_round_a == '0 && rsp_reply_a == '0 && rsp_round_b == '0 && rsp_reply_b == '0)
      else $error("intervals set outside final");

   // Both interval pairs span the same gap between the two responses
   a_interval_balance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_SEND_FINAL |->
         TIME_BITS'(rsp_reply_a - rsp_reply_b) == TIME_BITS'(rsp_round_b - rsp_round_a))
      else $error("final intervals inconsistent");

endmodule

bind two_way_ranging_tag_sequencer_core twr_checker u_twr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_action      (rsp_action),
   .rsp_action_time (rsp_action_time),
   .rsp_round_a     (rsp_round_a),
   .rsp_reply_a     (rsp_reply_a),
   .rsp_round_b     (rsp_round_b),
   .rsp_reply_b     (rsp_reply_b)
);

`default_nettype wire
